/* hdl/mbss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbss_pkg
// shared types, constants and codes of the masked byte signature scanner
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int PatternMax  = 32;
  localparam int AddrBits    = 32;
  localparam int ByteBits    = 8;
  localparam int PatBytes    = 32;
  localparam int PatWords    = 4;
  localparam int WordBytes   = 8;
  localparam int PatCap      = (PatternMax < PatBytes) ? PatternMax : PatBytes;
  localparam int PatIdxBits  = $clog2(PatBytes);
  localparam int FillBits    = $clog2(PatternMax + 1);
  localparam int LenBits     = 6;
  localparam int CmpBits     = (FillBits > LenBits) ? FillBits : LenBits;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 64;
  localparam int StatusBits  = 2;
  localparam int FifoDepth   = 2;
  localparam int FifoCntBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_MASK      = 3'd4,
    CFG_LENGTH    = 3'd5,
    CFG_UNIQUE    = 3'd6
  } mbss_cfg_idx_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_MATCH = 2'd1,
    STATUS_AMBIG = 2'd2
  } mbss_status_e;

  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic [AddrBits-1:0] byte_address;
    logic                section_start;
    logic                region_end;
  } mbss_in_t;

  typedef struct packed {
    mbss_status_e        status;
    logic [AddrBits-1:0] match_address;
  } mbss_out_t;

  typedef struct packed {
    logic [PatBytes-1:0][ByteBits-1:0] pattern;
    logic [PatBytes-1:0]               mask;
    logic [LenBits-1:0]                length;
    logic                              unique_en;
  } mbss_cfg_t;

  // item in the compare stage: window contents travel alongside
  typedef struct packed {
    logic                valid;
    logic [AddrBits-1:0] addr;
    logic                region_end;
    logic [FillBits-1:0] fill;
  } mbss_stage_t;

endpackage : mbss_pkg
`default_nettype wire

/* hdl/mbss_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbss_window
// input register stage: shift line of recent section bytes and fill count
// ----------------------------------------------------------------------------
module mbss_window import mbss_pkg::*; (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire mbss_in_t                            item_i,
  output mbss_stage_t                              stage_o,
  output logic [PatternMax-1:0][ByteBits-1:0]      window_o
);

  logic [PatternMax-1:0][ByteBits-1:0] window_q, window_d;
  logic [FillBits-1:0]                 fill_q, fill_d;
  logic                                end_seen_q;
  logic                                valid_q;
  logic [AddrBits-1:0]                 addr_q;
  logic                                region_end_q;
  logic                                restart;

  // a byte after region end opens a fresh section
  assign restart = item_i.section_start | end_seen_q;

  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    if (accept_i) begin
      if (restart) begin
        window_d = '0;
        fill_d   = FillBits'(1);
      end else begin
        for (int k = PatternMax - 1; k > 0; k--) begin
          window_d[k] = window_q[k-1];
        end
        if (fill_q != FillBits'(PatternMax)) begin
          fill_d = fill_q + FillBits'(1);
        end
      end
      window_d[0] = item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      end_seen_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      valid_q <= accept_i;
      if (accept_i) begin
        end_seen_q <= item_i.region_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    if (accept_i) begin
      addr_q       <= item_i.byte_address;
      region_end_q <= item_i.region_end;
    end
  end

  assign stage_o.valid      = valid_q;
  assign stage_o.addr       = addr_q;
  assign stage_o.region_end = region_end_q;
  assign stage_o.fill       = fill_q;
  assign window_o           = window_q;

endmodule : mbss_window
`default_nettype wire

/* hdl/mbss_match.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbss_match
// masked window compare, match tally and result build at region end
// ----------------------------------------------------------------------------
module mbss_match import mbss_pkg::*; (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mbss_cfg_t                           cfg_i,
  input  wire mbss_stage_t                         stage_i,
  input  wire logic [PatternMax-1:0][ByteBits-1:0] window_i,
  output logic                                     push_o,
  output mbss_out_t                                result_o
);

  // pattern re-aligned to window order, rebuilt from the registers each cycle
  logic [PatternMax-1:0][ByteBits-1:0] align_pat_q, align_pat_d;
  logic [PatternMax-1:0]               align_mask_q, align_mask_d;
  logic [LenBits-1:0]                  len_q, len_d;

  logic [1:0]          tally_q, tally_d;
  logic [AddrBits-1:0] first_q, first_d;
  logic                hit;
  logic [PatternMax-1:0] byte_ok;

  always_comb begin
    len_d = cfg_i.length;
    if (cfg_i.length == '0) begin
      len_d = LenBits'(1);
    end else if (cfg_i.length > LenBits'(PatCap)) begin
      len_d = LenBits'(PatCap);
    end
  end

  always_comb begin
    logic [LenBits-1:0] k;
    for (int j = 0; j < PatternMax; j++) begin
      k = len_d - LenBits'(1) - LenBits'(j);
      if (LenBits'(j) < len_d) begin
        align_pat_d[j]  = cfg_i.pattern[k[PatIdxBits-1:0]];
        align_mask_d[j] = cfg_i.mask[k[PatIdxBits-1:0]];
      end else begin
        align_pat_d[j]  = '0;
        align_mask_d[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    align_pat_q  <= align_pat_d;
    align_mask_q <= align_mask_d;
    len_q        <= len_d;
  end

  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      byte_ok[j] = !align_mask_q[j] || (window_i[j] == align_pat_q[j]);
    end
    hit = (CmpBits'(stage_i.fill) >= CmpBits'(len_q)) && (&byte_ok);
  end

  always_comb begin
    logic [1:0]          tally_n;
    logic [AddrBits-1:0] first_n;
    tally_n  = tally_q;
    first_n  = first_q;
    tally_d  = tally_q;
    first_d  = first_q;
    push_o   = 1'b0;
    result_o = '{status: STATUS_NONE, match_address: '0};
    if (stage_i.valid) begin
      if (hit) begin
        if (tally_q == 2'd0) begin
          tally_n = 2'd1;
          first_n = stage_i.addr - AddrBits'(len_q - LenBits'(1));
        end else begin
          tally_n = 2'd2;
        end
      end
      tally_d = tally_n;
      first_d = first_n;
      if (stage_i.region_end) begin
        push_o  = 1'b1;
        tally_d = 2'd0;
        first_d = '0;
        if (tally_n == 2'd0) begin
          result_o = '{status: STATUS_NONE, match_address: '0};
        end else if (cfg_i.unique_en && (tally_n == 2'd2)) begin
          result_o = '{status: STATUS_AMBIG, match_address: '0};
        end else begin
          result_o = '{status: STATUS_MATCH, match_address: first_n};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= 2'd0;
      first_q <= '0;
    end else begin
      tally_q <= tally_d;
      first_q <= first_d;
    end
  end

endmodule : mbss_match
`default_nettype wire

/* hdl/mbss_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbss_out_fifo
// two-entry result buffer in front of the output channel
// ----------------------------------------------------------------------------
module mbss_out_fifo import mbss_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire mbss_out_t              push_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output mbss_out_t                   out_data_o,
  output logic [FifoCntBits-1:0]      count_o,
  output logic                        pop_o
);

  mbss_out_t              mem_q [FifoDepth];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [FifoCntBits-1:0] count_q;

  assign out_valid_o = (count_q != '0);
  assign pop_o       = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + FifoCntBits'(push_i) - FifoCntBits'(pop_o);
    end
  end

endmodule : mbss_out_fifo
`default_nettype wire

/* hdl/masked_byte_signature_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner
// streaming search for a wildcard byte signature over sectioned memory
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock with its address and the section
// start and region end flags, and returns one result per region: no match,
// the start address of the first match, or ambiguous (unique mode, two or
// more matches). A new byte is taken every cycle unless the input stalls;
// the result of a region passes the window register, then compare and
// tally into a two-entry result buffer, before it leaves the output.
// Input stalls only when that buffer, together with a result still in the
// compare stage, has no room left. Pattern registers reach the compare
// stage through the configuration registers, then the aligned pattern registers.
module masked_byte_signature_scanner import mbss_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input byte stream
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire mbss_in_t               in_data_i,
  // result stream
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output mbss_out_t                   out_data_o,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i
);

  mbss_cfg_t                           cfg_q;
  mbss_stage_t                         stage;
  logic [PatternMax-1:0][ByteBits-1:0] window;
  logic                                in_accept;
  logic                                res_push;
  mbss_out_t                           res_data;
  logic [FifoCntBits-1:0]              fifo_count;
  logic                                fifo_pop;
  logic [FifoCntBits:0]                fill_need;
  logic [FifoCntBits:0]                fill_room;

  // configuration registers; the user must write them only while the scanner is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern   <= '0;
      cfg_q.mask      <= '0;
      cfg_q.length    <= LenBits'(1);
      cfg_q.unique_en <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mbss_cfg_idx_e'(cfg_idx_i))
        CFG_PAT_0_7:   cfg_q.pattern[0*WordBytes +: WordBytes] <= cfg_wdata_i;
        CFG_PAT_8_15:  cfg_q.pattern[1*WordBytes +: WordBytes] <= cfg_wdata_i;
        CFG_PAT_16_23: cfg_q.pattern[2*WordBytes +: WordBytes] <= cfg_wdata_i;
        CFG_PAT_24_31: cfg_q.pattern[3*WordBytes +: WordBytes] <= cfg_wdata_i;
        CFG_MASK:      cfg_q.mask      <= cfg_wdata_i[PatBytes-1:0];
        CFG_LENGTH:    cfg_q.length    <= cfg_wdata_i[LenBits-1:0];
        CFG_UNIQUE:    cfg_q.unique_en <= cfg_wdata_i[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // buffered results plus one possibly in the compare stage must fit the
  // buffer after this cycle's pop
  assign fill_need  = (FifoCntBits+1)'(fifo_count)
                    + (FifoCntBits+1)'(stage.valid && stage.region_end);
  assign fill_room  = (FifoCntBits+1)'(FifoDepth - 1) + (FifoCntBits+1)'(fifo_pop);
  assign in_stall_o = (fill_need > fill_room);
  assign in_accept  = in_valid_i && !in_stall_o;

  // window register stage
  mbss_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .stage_o  (stage),
    .window_o (window)
  );

  // compare, tally and result build
  mbss_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .stage_i  (stage),
    .window_i (window),
    .push_o   (res_push),
    .result_o (res_data)
  );

  // result buffer, parts the output transfer from the input side
  mbss_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_count),
    .pop_o       (fifo_pop)
  );

`ifndef ASSERT_OFF
  // a region end transfer produces its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.region_end) |=> res_push)
    else $error("region end transfer gave no result");

  // the result buffer is never pushed while full and not draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> ((fifo_count != FifoCntBits'(FifoDepth)) || fifo_pop))
    else $error("result buffer overflow");

  // occupancy stays within the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= FifoCntBits'(FifoDepth))
    else $error("result buffer count out of range");

  // ambiguous only in unique mode and never with an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STATUS_AMBIG))
      |-> (cfg_q.unique_en && (out_data_o.match_address == '0)))
    else $error("bad ambiguous result");
`endif

endmodule : masked_byte_signature_scanner
`default_nettype wire

/* sim/tb_masked_byte_signature_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_masked_byte_signature_scanner
// self-checking bench for the masked byte signature scanner
// ----------------------------------------------------------------------------
// Byte streams are driven into the scanner and every region verdict is
// checked against a predictor kept in a small scoreboard class. A directed
// opening covers address wrap, section boundaries, non-unique and unique
// verdicts, an all-wildcard pattern and a zero length. A random part
// follows in phases, each with a fresh pattern setup written while the
// scanner is idle. Regions are mostly well-formed sections with planted
// signatures, mixed with noise transfers. Sender and receiver idle at
// random, and one long receiver hold fills the result buffer so that the
// input stalls.
module tb_masked_byte_signature_scanner;
  import mbss_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 150;
  localparam int RandPhases  = 12;
  localparam int LongHold    = 400;
  localparam int SettleDelay = 6;

  // predictor of region verdicts plus the queue of verdicts still owed
  class signature_scoreboard;
    logic [63:0]   words [PatWords];
    logic [31:0]   mask;
    logic [5:0]    len;
    bit            unique_mode;
    logic [7:0]    window [PatternMax];
    int            fill;
    int            tally;
    logic [31:0]   first_addr;
    mbss_out_t     region_verdicts [$];
    int            error_count;

    function new();
      foreach (words[k]) words[k] = '0;
      mask        = '0;
      len         = 6'd1;
      unique_mode = 1'b0;
      error_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[k]) window[k] = '0;
      fill       = 0;
      tally      = 0;
      first_addr = '0;
    endfunction

    function int active_length();
      int n;
      n = len;
      if (n == 0) n = 1;
      if (n > PatCap) n = PatCap;
      return n;
    endfunction

    function logic [7:0] pattern_byte(int i);
      return words[i / WordBytes][(i % WordBytes) * 8 +: 8];
    endfunction

    function void set_reg(mbss_cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CFG_PAT_0_7:   words[0] = v;
        CFG_PAT_8_15:  words[1] = v;
        CFG_PAT_16_23: words[2] = v;
        CFG_PAT_24_31: words[3] = v;
        CFG_MASK:      mask = v[31:0];
        CFG_LENGTH:    len = v[5:0];
        CFG_UNIQUE:    unique_mode = v[0];
        default: ;
      endcase
    endfunction

    // one accepted byte: shift the window, tally a match, close the region
    function void note_byte(mbss_in_t it);
      int        n;
      bit        hit;
      mbss_out_t verdict;
      n = active_length();
      if (it.section_start) begin
        foreach (window[k]) window[k] = '0;
        fill = 0;
      end
      for (int k = PatternMax - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = it.data_byte;
      if (fill < PatternMax) fill++;
      // pattern byte 0 lines up with the oldest byte of the window
      hit = (fill >= n);
      for (int k = 0; k < n; k++) begin
        if (mask[k] && window[n-1-k] != pattern_byte(k)) hit = 1'b0;
      end
      if (hit) begin
        if (tally == 0) begin
          first_addr = it.byte_address - 32'(n - 1);
          tally      = 1;
        end else begin
          tally = 2;
        end
      end
      if (it.region_end) begin
        verdict.match_address = '0;
        if (tally == 0) begin
          verdict.status = STATUS_NONE;
        end else if (unique_mode && tally >= 2) begin
          verdict.status = STATUS_AMBIG;
        end else begin
          verdict.status        = STATUS_MATCH;
          verdict.match_address = first_addr;
        end
        region_verdicts.insert(region_verdicts.size(), verdict);
        clear_scan();
      end
    endfunction

    function void check_result(mbss_out_t got);
      mbss_out_t want;
      if (region_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict status %0d address %h", $time,
                 got.status, got.match_address);
        error_count++;
        return;
      end
      want = region_verdicts.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time,
                 want.status, got.status);
        error_count++;
      end
      if (got.match_address !== want.match_address) begin
        $display("%0t: match_address mismatch expected %h actual %h", $time,
                 want.match_address, got.match_address);
        error_count++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  mbss_in_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  mbss_out_t              out_data_o;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  signature_scoreboard scan_sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked   = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  bit last_was_end  = 1'b1;

  masked_byte_signature_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold when the stimulus asks for one
  initial out_stall_i <= 1'b0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_granted < holds_asked) begin
      out_stall_i   <= 1'b1;
      hold_left     <= LongHold;
      holds_granted <= holds_granted + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // every result transfer is checked against the oldest owed verdict
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) scan_sb.check_result(out_data_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic mbss_in_t make_item(logic [7:0] data, logic [31:0] addr,
                                         bit sec, bit last);
    mbss_in_t it;
    it.data_byte     = data;
    it.byte_address  = addr;
    it.section_start = sec;
    it.region_end    = last;
    return it;
  endfunction

  // offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(mbss_in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scan_sb.note_byte(it);
    items_sent++;
    last_was_end = it.region_end;
  endtask

  // wait until every owed verdict has come out, then let the pipe drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (scan_sb.region_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic write_reg(mbss_cfg_idx_e idx, logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    scan_sb.set_reg(idx, v);
  endtask

  function automatic logic [63:0] rand_word(int phase);
    if (phase == 1) return '1;
    if (phase == 2) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // fresh pattern setup per phase; early phases pin the extremes
  task automatic setup_pattern(int phase);
    logic [31:0] m;
    logic [5:0]  l;
    case (phase)
      0: begin m = '1; l = 6'd32; end
      1: begin m = $urandom(); l = 6'd1; end
      2: begin m = '0; l = 6'd63; end
      3: begin m = $urandom() | $urandom(); l = 6'd0; end
      4: begin m = '1; l = 6'd33; end
      default: begin
        case ($urandom_range(3))
          0: m = '1;
          1: m = $urandom();
          2: m = $urandom() | $urandom();
          default: m = $urandom() & $urandom();
        endcase
        l = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 8));
      end
    endcase
    write_reg(CFG_PAT_0_7, rand_word(phase));
    write_reg(CFG_PAT_8_15, rand_word(phase));
    write_reg(CFG_PAT_16_23, rand_word(phase));
    write_reg(CFG_PAT_24_31, rand_word(phase));
    write_reg(CFG_MASK, 64'(m));
    write_reg(CFG_LENGTH, 64'(l));
    write_reg(CFG_UNIQUE, 64'(phase % 2 == 1 ? 1'b1 : 1'($urandom_range(1))));
    cfg_we_i <= 1'b0;
  endtask

  // a region of one to three sections with consecutive addresses inside,
  // each section sometimes carrying one or two planted signatures
  task automatic send_region(int max_secs, int max_len);
    logic [7:0]  sec_data [96];
    logic [31:0] addr;
    int          n, nsec, slen, off, s, k, p;
    bit          sec_flag;
    n    = scan_sb.active_length();
    addr = $urandom();
    nsec = $urandom_range(1, max_secs);
    for (s = 0; s < nsec; s++) begin
      if (max_len > 0) slen = $urandom_range(1, max_len);
      else if ($urandom_range(7) == 0) slen = $urandom_range(n, 2 * n + 8);
      else slen = $urandom_range(1, n + 16);
      for (k = 0; k < slen; k++) begin
        sec_data[k] = ($urandom_range(3) == 0) ?
                      scan_sb.pattern_byte($urandom_range(PatBytes - 1)) : 8'($urandom());
      end
      for (p = 0; p < 2; p++) begin
        if (slen >= n && $urandom_range(99) < (p == 0 ? 45 : 20)) begin
          off = $urandom_range(0, slen - n);
          for (k = 0; k < n; k++) begin
            if (scan_sb.mask[k]) sec_data[off + k] = scan_sb.pattern_byte(k);
          end
        end
      end
      // occasional address jump, occasional missing section mark
      if (s > 0 && $urandom_range(4) == 0) addr = $urandom();
      sec_flag = (s == 0) ? 1'($urandom_range(1)) : ($urandom_range(9) != 0);
      for (k = 0; k < slen; k++) begin
        send_byte(make_item(sec_data[k], addr, sec_flag && k == 0,
                            s == nsec - 1 && k == slen - 1));
        addr++;
      end
    end
  endtask

  // fully random transfers, flags included
  task automatic send_noise();
    int cnt;
    cnt = $urandom_range(1, 8);
    repeat (cnt) begin
      send_byte(make_item(8'($urandom()), $urandom(), 1'($urandom_range(1)),
                          $urandom_range(99) < 15));
    end
  endtask

  initial begin
    int phase;
    int target;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_PAT_0_7;
    cfg_wdata_i <= '0;
    tx_idle_pct = 21;
    rx_idle_pct = 45;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pattern 00 ff ?? cd, length 4, first match wins
    write_reg(CFG_PAT_0_7, 64'h0000_0000_CD00_FF00);
    write_reg(CFG_PAT_8_15, '1);
    write_reg(CFG_PAT_16_23, '0);
    write_reg(CFG_PAT_24_31, {$urandom(), $urandom()});
    write_reg(CFG_MASK, 64'h0000_000B);
    write_reg(CFG_LENGTH, 64'd4);
    write_reg(CFG_UNIQUE, 64'd0);
    cfg_we_i <= 1'b0;

    // two matches, the first starting just below the address wrap
    send_byte(make_item(8'h00, 32'hFFFF_FFFE, 1'b1, 1'b0));
    send_byte(make_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_byte(make_item(8'h77, 32'h0000_0000, 1'b0, 1'b0));
    send_byte(make_item(8'hCD, 32'h0000_0001, 1'b0, 1'b0));
    send_byte(make_item(8'h00, 32'h0000_0002, 1'b0, 1'b0));
    send_byte(make_item(8'hFF, 32'h0000_0003, 1'b0, 1'b0));
    send_byte(make_item(8'h12, 32'h0000_0004, 1'b0, 1'b0));
    send_byte(make_item(8'hCD, 32'h0000_0005, 1'b0, 1'b1));
    // signature split over a section boundary must not match
    send_byte(make_item(8'h00, 32'h0000_0010, 1'b1, 1'b0));
    send_byte(make_item(8'hFF, 32'h0000_0011, 1'b0, 1'b0));
    send_byte(make_item(8'h11, 32'h0000_0012, 1'b1, 1'b0));
    send_byte(make_item(8'hCD, 32'h0000_0013, 1'b0, 1'b1));

    // unique mode: two matches give ambiguous
    settle();
    write_reg(CFG_UNIQUE, 64'd1);
    cfg_we_i <= 1'b0;
    send_byte(make_item(8'h00, 32'h8000_0000, 1'b1, 1'b0));
    send_byte(make_item(8'hFF, 32'h8000_0001, 1'b0, 1'b0));
    send_byte(make_item(8'h01, 32'h8000_0002, 1'b0, 1'b0));
    send_byte(make_item(8'hCD, 32'h8000_0003, 1'b0, 1'b0));
    send_byte(make_item(8'h00, 32'h8000_0004, 1'b0, 1'b0));
    send_byte(make_item(8'hFF, 32'h8000_0005, 1'b0, 1'b0));
    send_byte(make_item(8'h02, 32'h8000_0006, 1'b0, 1'b0));
    send_byte(make_item(8'hCD, 32'h8000_0007, 1'b0, 1'b1));
    // lone byte: window never fills
    send_byte(make_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1));

    // all wildcards with a zero length: acts as one byte, any byte matches
    settle();
    write_reg(CFG_MASK, 64'd0);
    write_reg(CFG_LENGTH, 64'd0);
    cfg_we_i <= 1'b0;
    send_byte(make_item(8'h00, 32'h0000_0000, 1'b1, 1'b1));
    // all wildcards, length 3, region too short for a full window
    settle();
    write_reg(CFG_LENGTH, 64'd3);
    cfg_we_i <= 1'b0;
    send_byte(make_item(8'hA5, 32'h0000_FFFF, 1'b1, 1'b0));
    send_byte(make_item(8'h5A, 32'h0001_0000, 1'b0, 1'b1));

    // random phases: receiver idles more, then sender, then neither
    for (phase = 0; phase < RandPhases; phase++) begin
      if (phase < RandPhases / 3) begin
        tx_idle_pct = 21;
        rx_idle_pct = 45;
      end else if (phase < 2 * RandPhases / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      settle();
      setup_pattern(phase);
      if (phase == RandPhases / 2) begin
        // long receiver hold while short regions keep coming: buffer fills
        tx_idle_pct = 0;
        holds_asked++;
        repeat (40) send_region(1, 3);
        tx_idle_pct = 45;
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_region(3, 0);
      end
      // close the region so the scanner is idle for the next setup
      if (!last_was_end) send_byte(make_item(8'($urandom()), $urandom(), 1'b0, 1'b1));
    end

    settle();
    if (scan_sb.region_verdicts.size() != 0) scan_sb.error_count++;
    if (scan_sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_masked_byte_signature_scanner
`default_nettype wire
